### sv/cpu6502_execute_unit_macros.svh
// assertion macros for the 6502 execute unit
`ifndef CPU6502_EXECUTE_UNIT_MACROS_SVH
`define CPU6502_EXECUTE_UNIT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define CEU_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// property checked on every rising clock edge, reset included
`define CEU_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

### sv/ceu_pkg.sv
// shared types and constants for the 6502 execute unit
`default_nettype none
package ceu_pkg;

    localparam logic [7:0] FLAG_C = 8'h01;
    localparam logic [7:0] FLAG_Z = 8'h02;
    localparam logic [7:0] FLAG_I = 8'h04;
    localparam logic [7:0] FLAG_D = 8'h08;
    localparam logic [7:0] FLAG_B = 8'h10;
    localparam logic [7:0] FLAG_U = 8'h20;
    localparam logic [7:0] FLAG_V = 8'h40;
    localparam logic [7:0] FLAG_N = 8'h80;

    localparam logic [7:0] SP_RESET     = 8'hFD;
    localparam logic [7:0] STATUS_RESET = 8'h24;

    localparam int IN_W  = 16;
    localparam int OUT_W = 56;

    // result request: fields from the highest bit down
    typedef struct packed {
        logic       not_executed;
        logic       branch_taken;
        logic [7:0] write_data;
        logic       write_enable;
        logic [7:0] status_out;
        logic [7:0] sp_out;
        logic [7:0] y_out;
        logic [7:0] x_out;
        logic [7:0] acc_out;
    } result_t;

    function automatic logic [7:0] with_nz(input logic [7:0] p, input logic [7:0] v);
        logic [7:0] q;
        q = p & ~(FLAG_N | FLAG_Z);
        if (v == 8'h00) q = q | FLAG_Z;
        q = q | (v & FLAG_N);
        return q;
    endfunction

endpackage
`default_nettype wire

### sv/cpu6502_execute_unit.sv
// 6502 execute unit: register file, alu and flag logic behind a stream interface
// Each request is an opcode and its operand byte; the unit updates A, X, Y, SP
// and the status byte and returns one result per request with the new register
// values, any memory or stack write byte, the branch decision and a
// not-executed flag. A request goes via the alu into the result register, so
// one request is accepted per clock while results are taken; the registers
// update on acceptance, so back-to-back requests see each other's effects.
// The result register parts the two sides: a new request enters when the
// result is empty or being taken. Decimal mode is not implemented.
`default_nettype none
module cpu6502_execute_unit (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [ceu_pkg::IN_W-1:0]   s_tdata,   // op[7:0], operand[15:8]
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [ceu_pkg::OUT_W-1:0]       m_tdata    // acc_out, x_out, y_out, sp_out,
                                                       // status_out, write_enable,
                                                       // write_data, branch_taken,
                                                       // not_executed, 5 zero bits
);
    import ceu_pkg::*;

    logic [7:0] a_reg, x_reg, y_reg, s_reg, p_reg;
    logic [7:0] a_next, x_next, y_next, s_next, p_next;
    logic [7:0] wd_next;
    logic       we_next, br_next, nx_next;
    logic       out_valid_reg;
    result_t    out_reg;
    logic       accept;

    logic [7:0] op, m;
    logic [8:0] sum;
    logic [7:0] add_m, add_r, cmp_src, sh_in, sh_r;
    logic [8:0] cmp_diff;
    logic       sh_cout;

    assign op = s_tdata[7:0];
    assign m  = s_tdata[15:8];

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        // shared adder: adc, or sbc with inverted operand
        add_m = (op[7:5] == 3'd7) ? ~m : m;
        sum   = {1'b0, a_reg} + {1'b0, add_m} + {8'h00, p_reg[0]};
        add_r = sum[7:0];
        // shared comparator register select
        unique case (op[7:5])
            3'd6:    cmp_src = (op[1:0] == 2'b01) ? a_reg : y_reg;
            default: cmp_src = (op[1:0] == 2'b01) ? a_reg : x_reg;
        endcase
        cmp_diff = {1'b0, cmp_src} - {1'b0, m};
        // shared shifter: accumulator or memory form
        sh_in = op[2] ? m : a_reg;
        if (!op[6]) begin
            sh_cout = sh_in[7];
            sh_r    = {sh_in[6:0], op[5] & p_reg[0]};
        end else begin
            sh_cout = sh_in[0];
            sh_r    = {op[5] & p_reg[0], sh_in[7:1]};
        end
    end

    always_comb begin
        a_next  = a_reg;
        x_next  = x_reg;
        y_next  = y_reg;
        s_next  = s_reg;
        p_next  = p_reg;
        wd_next = 8'h00;
        we_next = 1'b0;
        br_next = 1'b0;
        nx_next = 1'b0;
        if (op[1:0] == 2'b01 && op != 8'h89) begin
            unique case (op[7:5])
                3'd0: begin a_next = a_reg | m; p_next = with_nz(p_reg, a_next); end
                3'd1: begin a_next = a_reg & m; p_next = with_nz(p_reg, a_next); end
                3'd2: begin a_next = a_reg ^ m; p_next = with_nz(p_reg, a_next); end
                3'd4: begin we_next = 1'b1; wd_next = a_reg; end
                3'd5: begin a_next = m; p_next = with_nz(p_reg, m); end
                3'd6: p_next = with_nz({p_reg[7:1], ~cmp_diff[8]}, cmp_diff[7:0]);
                default: begin
                    a_next = add_r;
                    p_next = with_nz({p_reg[7], ~(a_reg[7] ^ add_m[7]) & (a_reg[7] ^ add_r[7]),
                                      p_reg[5:1], sum[8]}, add_r);
                end
            endcase
        end else begin
            unique case (op)
                8'h0A, 8'h2A, 8'h4A, 8'h6A: begin
                    a_next = sh_r;
                    p_next = with_nz({p_reg[7:1], sh_cout}, sh_r);
                end
                8'h06, 8'h0E, 8'h16, 8'h1E, 8'h26, 8'h2E, 8'h36, 8'h3E,
                8'h46, 8'h4E, 8'h56, 8'h5E, 8'h66, 8'h6E, 8'h76, 8'h7E: begin
                    wd_next = sh_r; we_next = 1'b1;
                    p_next  = with_nz({p_reg[7:1], sh_cout}, sh_r);
                end
                8'hE6, 8'hEE, 8'hF6, 8'hFE: begin
                    wd_next = m + 8'h01; we_next = 1'b1; p_next = with_nz(p_reg, wd_next);
                end
                8'hC6, 8'hCE, 8'hD6, 8'hDE: begin
                    wd_next = m - 8'h01; we_next = 1'b1; p_next = with_nz(p_reg, wd_next);
                end
                8'h84, 8'h8C, 8'h94: begin we_next = 1'b1; wd_next = y_reg; end
                8'h86, 8'h8E, 8'h96: begin we_next = 1'b1; wd_next = x_reg; end
                8'hA0, 8'hA4, 8'hAC, 8'hB4, 8'hBC: begin
                    y_next = m; p_next = with_nz(p_reg, m);
                end
                8'hA2, 8'hA6, 8'hAE, 8'hB6, 8'hBE: begin
                    x_next = m; p_next = with_nz(p_reg, m);
                end
                8'hC0, 8'hC4, 8'hCC, 8'hE0, 8'hE4, 8'hEC:
                    p_next = with_nz({p_reg[7:1], ~cmp_diff[8]}, cmp_diff[7:0]);
                8'h24, 8'h2C: begin
                    p_next = (p_reg & ~(FLAG_N | FLAG_V | FLAG_Z)) | (m & (FLAG_N | FLAG_V));
                    if ((a_reg & m) == 8'h00) p_next = p_next | FLAG_Z;
                end
                8'h8A: begin a_next = x_reg; p_next = with_nz(p_reg, x_reg); end
                8'h98: begin a_next = y_reg; p_next = with_nz(p_reg, y_reg); end
                8'hAA: begin x_next = a_reg; p_next = with_nz(p_reg, a_reg); end
                8'hA8: begin y_next = a_reg; p_next = with_nz(p_reg, a_reg); end
                8'hBA: begin x_next = s_reg; p_next = with_nz(p_reg, s_reg); end
                8'h9A: s_next = x_reg;
                8'hE8: begin x_next = x_reg + 8'h01; p_next = with_nz(p_reg, x_next); end
                8'hC8: begin y_next = y_reg + 8'h01; p_next = with_nz(p_reg, y_next); end
                8'hCA: begin x_next = x_reg - 8'h01; p_next = with_nz(p_reg, x_next); end
                8'h88: begin y_next = y_reg - 8'h01; p_next = with_nz(p_reg, y_next); end
                8'h48: begin we_next = 1'b1; wd_next = a_reg; s_next = s_reg - 8'h01; end
                8'h08: begin
                    we_next = 1'b1; wd_next = p_reg | FLAG_B; s_next = s_reg - 8'h01;
                end
                8'h68: begin
                    s_next = s_reg + 8'h01; a_next = m; p_next = with_nz(p_reg, m);
                end
                8'h28: begin s_next = s_reg + 8'h01; p_next = m | FLAG_U; end
                8'h18: p_next = p_reg & ~FLAG_C;
                8'h38: p_next = p_reg | FLAG_C;
                8'h58: p_next = p_reg & ~FLAG_I;
                8'h78: p_next = p_reg | FLAG_I;
                8'hD8: p_next = p_reg & ~FLAG_D;
                8'hF8: p_next = p_reg | FLAG_D;
                8'hB8: p_next = p_reg & ~FLAG_V;
                8'h10: br_next = (p_reg & FLAG_N) == 8'h00;
                8'h30: br_next = (p_reg & FLAG_N) != 8'h00;
                8'h50: br_next = (p_reg & FLAG_V) == 8'h00;
                8'h70: br_next = (p_reg & FLAG_V) != 8'h00;
                8'h90: br_next = (p_reg & FLAG_C) == 8'h00;
                8'hB0: br_next = (p_reg & FLAG_C) != 8'h00;
                8'hD0: br_next = (p_reg & FLAG_Z) == 8'h00;
                8'hF0: br_next = (p_reg & FLAG_Z) != 8'h00;
                8'hEA: ;
                default: nx_next = 1'b1;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_reg         <= 8'h00;
            x_reg         <= 8'h00;
            y_reg         <= 8'h00;
            s_reg         <= SP_RESET;
            p_reg         <= STATUS_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                a_reg <= a_next;
                x_reg <= x_next;
                y_reg <= y_next;
                s_reg <= s_next;
                p_reg <= p_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_reg <= '{not_executed: nx_next, branch_taken: br_next,
                         write_data: wd_next, write_enable: we_next,
                         status_out: p_next, sp_out: s_next, y_out: y_next,
                         x_out: x_next, acc_out: a_next};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b00000, out_reg.not_executed, out_reg.branch_taken,
                       out_reg.write_data, out_reg.write_enable, out_reg.status_out,
                       out_reg.sp_out, out_reg.y_out, out_reg.x_out, out_reg.acc_out};

`include "cpu6502_execute_unit_macros.svh"

    `CEU_ASSERT(a_status_bit5, !m_tvalid || m_tdata[37], "status bit 5 clear in result")
    `CEU_ASSERT(a_wd_zero, !m_tvalid || m_tdata[40] || m_tdata[48:41] == 8'h00, "write data without write enable")
    `CEU_ASSERT(a_nx_quiet, !m_tvalid || !m_tdata[50] || !m_tdata[40] && !m_tdata[49], "not executed result has side effects")
    `CEU_ASSERT(a_ready, !out_valid_reg |-> s_tready, "not ready while result register empty")
    `CEU_ASSERT_ALWAYS(a_reset_empty, !aresetn |=> !m_tvalid, "result valid right after reset")

endmodule
`default_nettype wire

### verif/cpu6502_execute_unit_test.sv
// stream testbench for the 6502 execute unit with an opcode-level predictor
`default_nettype none
module cpu6502_execute_unit_test;
    import ceu_pkg::*;

    localparam int STALL_LIMIT = 2000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // op[7:0], operand[15:8]
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;   // acc, x, y, sp, status, write_enable, write_data,
                            // branch_taken, not_executed, 5 zero bits

    cpu6502_execute_unit u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    typedef struct {
        logic [7:0] acc, x, y, sp, st;
        logic       we;
        logic [7:0] wd;
        logic       br, nx;
    } exec_result_t;

    exec_result_t expected_results[$];
    logic [7:0] reg_a, reg_x, reg_y, reg_s, reg_p;
    int mismatches;
    int idle_cycles;
    bit timed_out;
    bit hold_sink;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    function automatic logic [7:0] nz(input logic [7:0] p, input logic [7:0] v);
        logic [7:0] q;
        q = p & ~(FLAG_N | FLAG_Z);
        if (v == 8'h00) q |= FLAG_Z;
        q |= v & FLAG_N;
        return q;
    endfunction

    function automatic logic [7:0] adc8(input logic [7:0] a, input logic [7:0] m,
                                         inout logic [7:0] p);
        logic [8:0] t;
        logic [7:0] r, q;
        t = {1'b0, a} + {1'b0, m} + {8'h00, p[0]};
        r = t[7:0];
        q = p & ~(FLAG_C | FLAG_V);
        if ((~(a ^ m) & (a ^ r) & 8'h80) != 8'h00) q |= FLAG_V;
        if (t[8]) q |= FLAG_C;
        p = nz(q, r);
        return r;
    endfunction

    function automatic logic [7:0] cmp8(input logic [7:0] r, input logic [7:0] m,
                                         input logic [7:0] p);
        p = p & ~FLAG_C;
        if (r >= m) p |= FLAG_C;
        return nz(p, r - m);
    endfunction

    // kind from op[6:5]: asl, rol, lsr, ror
    function automatic logic [7:0] shift8(input logic [1:0] kind, input logic [7:0] v,
                                           inout logic [7:0] p);
        logic [7:0] r;
        logic c;
        if (!kind[1]) begin
            c = v[7];
            r = {v[6:0], kind[0] & p[0]};
        end else begin
            c = v[0];
            r = {kind[0] & p[0], v[7:1]};
        end
        p = nz({p[7:1], c}, r);
        return r;
    endfunction

    function automatic exec_result_t execute_op(input logic [7:0] op, input logic [7:0] m);
        exec_result_t e;
        logic [7:0] a, x, y, s, p, wd;
        logic we, br, nx;
        a = reg_a; x = reg_x; y = reg_y; s = reg_s; p = reg_p;
        wd = 8'h00; we = 1'b0; br = 1'b0; nx = 1'b0;
        if (op[1:0] == 2'b01 && op != 8'h89) begin
            case (op[7:5])
                3'd0: begin a = a | m; p = nz(p, a); end
                3'd1: begin a = a & m; p = nz(p, a); end
                3'd2: begin a = a ^ m; p = nz(p, a); end
                3'd3: a = adc8(a, m, p);
                3'd4: begin we = 1'b1; wd = a; end
                3'd5: begin a = m; p = nz(p, a); end
                3'd6: p = cmp8(a, m, p);
                default: a = adc8(a, ~m, p);
            endcase
        end else begin
            case (op)
                8'h0A, 8'h2A, 8'h4A, 8'h6A: a = shift8(op[6:5], a, p);
                8'h06, 8'h0E, 8'h16, 8'h1E, 8'h26, 8'h2E, 8'h36, 8'h3E,
                8'h46, 8'h4E, 8'h56, 8'h5E, 8'h66, 8'h6E, 8'h76, 8'h7E: begin
                    wd = shift8(op[6:5], m, p); we = 1'b1;
                end
                8'hE6, 8'hEE, 8'hF6, 8'hFE: begin wd = m + 8'd1; p = nz(p, wd); we = 1'b1; end
                8'hC6, 8'hCE, 8'hD6, 8'hDE: begin wd = m - 8'd1; p = nz(p, wd); we = 1'b1; end
                8'h84, 8'h8C, 8'h94: begin we = 1'b1; wd = y; end
                8'h86, 8'h8E, 8'h96: begin we = 1'b1; wd = x; end
                8'hA0, 8'hA4, 8'hAC, 8'hB4, 8'hBC: begin y = m; p = nz(p, y); end
                8'hA2, 8'hA6, 8'hAE, 8'hB6, 8'hBE: begin x = m; p = nz(p, x); end
                8'hC0, 8'hC4, 8'hCC: p = cmp8(y, m, p);
                8'hE0, 8'hE4, 8'hEC: p = cmp8(x, m, p);
                8'h24, 8'h2C: begin
                    p = (p & ~(FLAG_N | FLAG_V | FLAG_Z)) | (m & (FLAG_N | FLAG_V));
                    if ((a & m) == 8'h00) p |= FLAG_Z;
                end
                8'h8A: begin a = x; p = nz(p, a); end
                8'h98: begin a = y; p = nz(p, a); end
                8'hAA: begin x = a; p = nz(p, x); end
                8'hA8: begin y = a; p = nz(p, y); end
                8'hBA: begin x = s; p = nz(p, x); end
                8'h9A: s = x;
                8'hE8: begin x = x + 8'd1; p = nz(p, x); end
                8'hC8: begin y = y + 8'd1; p = nz(p, y); end
                8'hCA: begin x = x - 8'd1; p = nz(p, x); end
                8'h88: begin y = y - 8'd1; p = nz(p, y); end
                8'h48: begin we = 1'b1; wd = a; s = s - 8'd1; end
                8'h08: begin we = 1'b1; wd = p | FLAG_B; s = s - 8'd1; end
                8'h68: begin s = s + 8'd1; a = m; p = nz(p, a); end
                8'h28: begin s = s + 8'd1; p = m | FLAG_U; end
                8'h18: p = p & ~FLAG_C;
                8'h38: p = p | FLAG_C;
                8'h58: p = p & ~FLAG_I;
                8'h78: p = p | FLAG_I;
                8'hD8: p = p & ~FLAG_D;
                8'hF8: p = p | FLAG_D;
                8'hB8: p = p & ~FLAG_V;
                8'h10: br = (p & FLAG_N) == 8'h00;
                8'h30: br = (p & FLAG_N) != 8'h00;
                8'h50: br = (p & FLAG_V) == 8'h00;
                8'h70: br = (p & FLAG_V) != 8'h00;
                8'h90: br = (p & FLAG_C) == 8'h00;
                8'hB0: br = (p & FLAG_C) != 8'h00;
                8'hD0: br = (p & FLAG_Z) == 8'h00;
                8'hF0: br = (p & FLAG_Z) != 8'h00;
                8'hEA: ;
                default: nx = 1'b1;
            endcase
        end
        reg_a = a; reg_x = x; reg_y = y; reg_s = s; reg_p = p;
        e.acc = a; e.x = x; e.y = y; e.sp = s; e.st = p;
        e.we = we; e.wd = we ? wd : 8'h00; e.br = br; e.nx = nx;
        return e;
    endfunction

    // valid stays high between back-to-back requests; dropped only for a gap
    task automatic send_op(input logic [7:0] op, input logic [7:0] operand);
        int gap;
        gap = $urandom_range(0, 8);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {operand, op};
        // ready is stable from the falling edge to the next rising edge
        @(negedge aclk);
        while (!s_tready) @(negedge aclk);
        @(posedge aclk);
        expected_results.push_back(execute_op(op, operand));
    endtask

    // result checker, sampled at the falling edge before the accepting edge
    initial begin
        exec_result_t e;
        logic [55:0] want;
        forever begin
            @(negedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                if (expected_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result %h", m_tdata);
                end else begin
                    e = expected_results.pop_front();
                    want = {5'b00000, e.nx, e.br, e.wd, e.we, e.st, e.sp, e.y, e.x, e.acc};
                    if (m_tdata !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("result mismatch: expected %h actual %h", want, m_tdata);
                    end
                end
            end
        end
    end

    // receiver stalls
    initial begin
        int gap;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_sink) m_tready <= 1'b0;
            else if (m_tready && m_tvalid) begin
                gap = $urandom_range(0, 8);
                if (gap > 0 && $urandom_range(0, 3) != 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                    m_tready <= 1'b1;
                end
            end else m_tready <= 1'b1;
        end
    end

    // watchdog on accepted requests and results
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                timed_out = 1'b1;
                $display("cpu6502_execute_unit_test: done, errors");
                $finish;
            end
        end
    end

    task automatic test_directed();
        logic [7:0] ops[$];
        ops = {8'hA9, 8'hA2, 8'hA0, 8'h69, 8'hE9, 8'h29, 8'h09, 8'h49, 8'hC9, 8'h24,
               8'h0A, 8'h2A, 8'h4A, 8'h6A, 8'h48, 8'h08, 8'h68, 8'h28, 8'h10, 8'hF0,
               8'h00, 8'h4C, 8'h02, 8'hEA, 8'h89};
        foreach (ops[i]) send_op(ops[i], (i % 2) ? 8'hFF : 8'h00);
        send_op(8'hA9, 8'h7F);
        send_op(8'h69, 8'h01);
        send_op(8'hE6, 8'hFF);
        send_op(8'hC6, 8'h00);
    endtask

    task automatic test_random_ops(input int count);
        for (int i = 0; i < count; i++)
            send_op(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    // stack pointer wrap through page one
    task automatic test_stack_wrap();
        send_op(8'hA2, 8'h00);
        send_op(8'h9A, 8'($urandom_range(0, 255)));
        send_op(8'h48, 8'($urandom_range(0, 255)));
        send_op(8'h68, 8'h80);
        send_op(8'h68, 8'h00);
        send_op(8'hBA, 8'h00);
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_sink = 1'b1;
                repeat (60) @(posedge aclk);
                hold_sink = 1'b0;
            end
            test_random_ops(20);
        join
    endtask

    initial begin
        int drain;
        mismatches = 0;
        timed_out = 1'b0;
        hold_sink = 1'b0;
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 16'h0000;
        reg_a = 8'h00; reg_x = 8'h00; reg_y = 8'h00;
        reg_s = SP_RESET; reg_p = STATUS_RESET;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_stack_wrap();
        test_backpressure();
        test_random_ops(1100);
        s_tvalid <= 1'b0;
        drain = 0;
        while (expected_results.size() != 0 && drain < 100000) begin
            @(posedge aclk);
            drain++;
        end
        repeat (10) @(posedge aclk);
        if (mismatches == 0 && expected_results.size() == 0 && !timed_out)
            $display("cpu6502_execute_unit_test: done, clean");
        else
            $display("cpu6502_execute_unit_test: done, errors");
        $finish;
    end
endmodule
`default_nettype wire
